/* design/mieu_pkg.sv */
// ----------------------------------------------------------------------------
// mieu_pkg
// Shared types, class codes and constants of the integer execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mieu_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CLS_ALU = 2'd0;
    localparam logic [1:0] CLS_MUL = 2'd1;
    localparam logic [1:0] CLS_DIV = 2'd2;
    localparam logic [1:0] CLS_BAD = 2'd3;

    localparam logic [5:0] OPC_SPECIAL = 6'd0;
    localparam logic [5:0] OPC_ADDI    = 6'd8;
    localparam logic [5:0] OPC_ADDIU   = 6'd9;
    localparam logic [5:0] OPC_SLTI    = 6'd10;
    localparam logic [5:0] OPC_SLTIU   = 6'd11;
    localparam logic [5:0] OPC_ANDI    = 6'd12;
    localparam logic [5:0] OPC_ORI     = 6'd13;
    localparam logic [5:0] OPC_XORI    = 6'd14;
    localparam logic [5:0] OPC_LUI     = 6'd15;
    localparam logic [5:0] OPC_SPECIAL3 = 6'd31;

    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_SRA   = 6'd3;
    localparam logic [5:0] FN_SLLV  = 6'd4;
    localparam logic [5:0] FN_SRLV  = 6'd6;
    localparam logic [5:0] FN_SRAV  = 6'd7;
    localparam logic [5:0] FN_MOVZ  = 6'd10;
    localparam logic [5:0] FN_MOVN  = 6'd11;
    localparam logic [5:0] FN_MFHI  = 6'd16;
    localparam logic [5:0] FN_MTHI  = 6'd17;
    localparam logic [5:0] FN_MFLO  = 6'd18;
    localparam logic [5:0] FN_MTLO  = 6'd19;
    localparam logic [5:0] FN_CLZ   = 6'd22;
    localparam logic [5:0] FN_CLO   = 6'd23;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_DIV   = 6'd26;
    localparam logic [5:0] FN_DIVU  = 6'd27;
    localparam logic [5:0] FN_MADD  = 6'd28;
    localparam logic [5:0] FN_MADDU = 6'd29;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_ADDU  = 6'd33;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_SUBU  = 6'd35;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_XOR   = 6'd38;
    localparam logic [5:0] FN_NOR   = 6'd39;
    localparam logic [5:0] FN_SLT   = 6'd42;
    localparam logic [5:0] FN_SLTU  = 6'd43;
    localparam logic [5:0] FN_MAX   = 6'd44;
    localparam logic [5:0] FN_MIN   = 6'd45;
    localparam logic [5:0] FN_EXT   = 6'd0;
    localparam logic [5:0] FN_INS   = 6'd4;
    localparam logic [5:0] FN_BSHFL = 6'd32;

    localparam logic [4:0] SA_WSBH   = 5'd2;
    localparam logic [4:0] SA_WSBW   = 5'd3;
    localparam logic [4:0] SA_SEB    = 5'd16;
    localparam logic [4:0] SA_BITREV = 5'd20;
    localparam logic [4:0] SA_SEH    = 5'd24;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
    } t_req;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  dest_register;
        logic [31:0] write_value;
        logic        unsupported;
    } t_rsp;

    typedef struct packed {
        logic [1:0]  cls;
        logic        sgn;
        logic        acc;
        t_req        req;
    } t_dec;

endpackage

`default_nettype wire

/* design/mieu_front.sv */
// ----------------------------------------------------------------------------
// mieu_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mieu_front #(
    parameter int Depth = mieu_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  mieu_pkg::t_req   i_req,
    output logic             o_full,
    output logic             o_valid,
    output mieu_pkg::t_dec   o_dec,
    input  wire              i_take
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    mieu_pkg::t_dec    r_mem [Depth];
    logic [PtrW-1:0]   r_wptr, n_wptr;
    logic [PtrW-1:0]   r_rptr, n_rptr;
    logic [CntW-1:0]   r_cnt, n_cnt;
    mieu_pkg::t_dec    w_dec;
    logic              w_wr;
    logic              w_rd;

    always_comb begin
        logic [5:0] opc;
        logic [5:0] fn;
        logic [4:0] sa;
        opc = i_req.instruction[31:26];
        fn  = i_req.instruction[5:0];
        sa  = i_req.instruction[10:6];
        w_dec     = '0;
        w_dec.req = i_req;
        w_dec.cls = mieu_pkg::CLS_BAD;
        if (opc == mieu_pkg::OPC_SPECIAL) begin
            unique case (fn)
                mieu_pkg::FN_SLL, mieu_pkg::FN_SRL, mieu_pkg::FN_SRA,
                mieu_pkg::FN_SLLV, mieu_pkg::FN_SRLV, mieu_pkg::FN_SRAV,
                mieu_pkg::FN_MOVZ, mieu_pkg::FN_MOVN,
                mieu_pkg::FN_MFHI, mieu_pkg::FN_MTHI, mieu_pkg::FN_MFLO, mieu_pkg::FN_MTLO,
                mieu_pkg::FN_CLZ, mieu_pkg::FN_CLO,
                mieu_pkg::FN_ADD, mieu_pkg::FN_ADDU, mieu_pkg::FN_SUB, mieu_pkg::FN_SUBU,
                mieu_pkg::FN_AND, mieu_pkg::FN_OR, mieu_pkg::FN_XOR, mieu_pkg::FN_NOR,
                mieu_pkg::FN_SLT, mieu_pkg::FN_SLTU, mieu_pkg::FN_MAX, mieu_pkg::FN_MIN: begin
                    w_dec.cls = mieu_pkg::CLS_ALU;
                end
                mieu_pkg::FN_MULT, mieu_pkg::FN_MADD: begin
                    w_dec.cls = mieu_pkg::CLS_MUL;
                    w_dec.sgn = 1'b1;
                    w_dec.acc = (fn == mieu_pkg::FN_MADD);
                end
                mieu_pkg::FN_MULTU, mieu_pkg::FN_MADDU: begin
                    w_dec.cls = mieu_pkg::CLS_MUL;
                    w_dec.acc = (fn == mieu_pkg::FN_MADDU);
                end
                mieu_pkg::FN_DIV: begin
                    w_dec.cls = mieu_pkg::CLS_DIV;
                    w_dec.sgn = 1'b1;
                end
                mieu_pkg::FN_DIVU: begin
                    w_dec.cls = mieu_pkg::CLS_DIV;
                end
                default: begin
                    w_dec.cls = mieu_pkg::CLS_BAD;
                end
            endcase
        end else if (opc >= mieu_pkg::OPC_ADDI && opc <= mieu_pkg::OPC_LUI) begin
            w_dec.cls = mieu_pkg::CLS_ALU;
        end else if (opc == mieu_pkg::OPC_SPECIAL3) begin
            if (fn == mieu_pkg::FN_EXT || fn == mieu_pkg::FN_INS) begin
                w_dec.cls = mieu_pkg::CLS_ALU;
            end else if (fn == mieu_pkg::FN_BSHFL &&
                         (sa == mieu_pkg::SA_SEB || sa == mieu_pkg::SA_SEH ||
                          sa == mieu_pkg::SA_BITREV || sa == mieu_pkg::SA_WSBH ||
                          sa == mieu_pkg::SA_WSBW)) begin
                w_dec.cls = mieu_pkg::CLS_ALU;
            end
        end
    end

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        o_dec  = r_mem[r_rptr];
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == PtrW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PtrW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* design/mieu_back.sv */
// ----------------------------------------------------------------------------
// mieu_back
// Executes queued requests: combinational ALU, registered multiplier,
// bit-serial divider, HI/LO pair and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mieu_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  mieu_pkg::t_dec   i_dec,
    output logic             o_take,
    output logic             o_empty,
    output mieu_pkg::t_rsp   o_rsp,
    input  wire              i_pop
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]     r_state;
    logic [31:0]    r_hi;
    logic [31:0]    r_lo;
    logic           r_out_valid;
    mieu_pkg::t_rsp r_out;
    logic [63:0]    r_prod;
    logic           r_acc;
    logic [31:0]    r_rem;
    logic [31:0]    r_quo;
    logic [31:0]    r_dvs;
    logic [4:0]     r_cnt;
    logic           r_qneg;
    logic           r_rneg;

    logic           w_slot;
    logic           w_load;
    mieu_pkg::t_rsp w_alu;
    logic [31:0]    w_hi_alu;
    logic [31:0]    w_lo_alu;
    logic [63:0]    w_mac;
    logic [32:0]    w_rem_sh;
    logic [32:0]    w_rem_sub;
    logic [31:0]    w_amag;
    logic [31:0]    w_bmag;
    logic [31:0]    w_quo_nx;
    logic [31:0]    w_rem_nx;

    function automatic logic [31:0] lead_zeros(input logic [31:0] v);
        logic [31:0] n;
        n = 32'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 32'(31 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] rot_right(input logic [31:0] v, input logic [4:0] s);
        return (v >> s) | (v << (6'd32 - {1'b0, s}));
    endfunction

    function automatic logic [31:0] bit_rev(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    assign w_slot = !r_out_valid || i_pop;
    assign o_take = (r_state == ST_IDLE) && i_valid && w_slot;
    assign w_load = o_take && (i_dec.cls == mieu_pkg::CLS_ALU || i_dec.cls == mieu_pkg::CLS_BAD);
    assign o_empty = !r_out_valid;
    assign o_rsp   = r_out;

    always_comb begin
        logic [31:0] ins;
        logic [31:0] a;
        logic [31:0] b;
        logic [5:0]  opc;
        logic [5:0]  fn;
        logic [4:0]  rsf;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic [31:0] uimm;
        logic [31:0] simm;
        logic [31:0] mask;
        logic [31:0] smask;
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] val;
        ins  = i_dec.req.instruction;
        a    = i_dec.req.rs_value;
        b    = i_dec.req.rt_value;
        opc  = ins[31:26];
        rsf  = ins[25:21];
        rt   = ins[20:16];
        rd   = ins[15:11];
        sa   = ins[10:6];
        fn   = ins[5:0];
        uimm = {16'd0, ins[15:0]};
        simm = {{16{ins[15]}}, ins[15:0]};
        mask = 32'hFFFF_FFFF >> (5'd31 - rd);
        smask = mask >> sa;
        wr   = 1'b1;
        dst  = rd;
        val  = '0;
        w_hi_alu = r_hi;
        w_lo_alu = r_lo;
        if (opc == mieu_pkg::OPC_SPECIAL) begin
            unique case (fn)
                mieu_pkg::FN_SLL:  val = b << sa;
                mieu_pkg::FN_SRL:  val = (rsf == 5'd1) ? rot_right(b, sa) : (b >> sa);
                mieu_pkg::FN_SRA:  val = 32'($signed(b) >>> sa);
                mieu_pkg::FN_SLLV: val = b << a[4:0];
                mieu_pkg::FN_SRLV: val = (sa == 5'd1) ? rot_right(b, a[4:0]) : (b >> a[4:0]);
                mieu_pkg::FN_SRAV: val = 32'($signed(b) >>> a[4:0]);
                mieu_pkg::FN_MOVZ: begin
                    wr  = (b == '0);
                    val = a;
                end
                mieu_pkg::FN_MOVN: begin
                    wr  = (b != '0);
                    val = a;
                end
                mieu_pkg::FN_MFHI: val = r_hi;
                mieu_pkg::FN_MTHI: begin
                    wr = 1'b0;
                    w_hi_alu = a;
                end
                mieu_pkg::FN_MFLO: val = r_lo;
                mieu_pkg::FN_MTLO: begin
                    wr = 1'b0;
                    w_lo_alu = a;
                end
                mieu_pkg::FN_CLZ:  val = lead_zeros(a);
                mieu_pkg::FN_CLO:  val = lead_zeros(~a);
                mieu_pkg::FN_ADD, mieu_pkg::FN_ADDU: val = a + b;
                mieu_pkg::FN_SUB, mieu_pkg::FN_SUBU: val = a - b;
                mieu_pkg::FN_AND:  val = a & b;
                mieu_pkg::FN_OR:   val = a | b;
                mieu_pkg::FN_XOR:  val = a ^ b;
                mieu_pkg::FN_NOR:  val = ~(a | b);
                mieu_pkg::FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                mieu_pkg::FN_SLTU: val = {31'd0, a < b};
                mieu_pkg::FN_MAX:  val = ($signed(a) > $signed(b)) ? a : b;
                mieu_pkg::FN_MIN:  val = ($signed(a) < $signed(b)) ? a : b;
                default:           wr = 1'b0;
            endcase
        end else if (opc == mieu_pkg::OPC_SPECIAL3) begin
            if (fn == mieu_pkg::FN_EXT) begin
                dst = rt;
                val = (a >> sa) & mask;
            end else if (fn == mieu_pkg::FN_INS) begin
                dst = rt;
                val = (b & ~(smask << sa)) | ((a & smask) << sa);
            end else begin
                unique case (sa)
                    mieu_pkg::SA_SEB:    val = {{24{b[7]}}, b[7:0]};
                    mieu_pkg::SA_SEH:    val = {{16{b[15]}}, b[15:0]};
                    mieu_pkg::SA_BITREV: val = bit_rev(b);
                    mieu_pkg::SA_WSBH:   val = {b[23:16], b[31:24], b[7:0], b[15:8]};
                    mieu_pkg::SA_WSBW:   val = {b[7:0], b[15:8], b[23:16], b[31:24]};
                    default:             wr = 1'b0;
                endcase
            end
        end else begin
            dst = rt;
            unique case (opc)
                mieu_pkg::OPC_SLTI:  val = {31'd0, $signed(a) < $signed(simm)};
                mieu_pkg::OPC_SLTIU: val = {31'd0, a < simm};
                mieu_pkg::OPC_ANDI:  val = a & uimm;
                mieu_pkg::OPC_ORI:   val = a | uimm;
                mieu_pkg::OPC_XORI:  val = a ^ uimm;
                mieu_pkg::OPC_LUI:   val = {ins[15:0], 16'd0};
                default:             val = a + simm;
            endcase
        end
        w_alu = '0;
        if (i_dec.cls == mieu_pkg::CLS_BAD) begin
            w_alu.unsupported = 1'b1;
        end else if (wr && dst != 5'd0) begin
            w_alu.write_enable  = 1'b1;
            w_alu.dest_register = dst;
            w_alu.write_value   = val;
        end
    end

    assign w_mac     = r_acc ? ({r_hi, r_lo} + r_prod) : r_prod;
    assign w_amag    = (i_dec.sgn && i_dec.req.rs_value[31]) ?
                       (32'd0 - i_dec.req.rs_value) : i_dec.req.rs_value;
    assign w_bmag    = (i_dec.sgn && i_dec.req.rt_value[31]) ?
                       (32'd0 - i_dec.req.rt_value) : i_dec.req.rt_value;
    assign w_rem_sh  = {r_rem, r_quo[31]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};
    assign w_rem_nx  = w_rem_sub[32] ? w_rem_sh[31:0] : w_rem_sub[31:0];
    assign w_quo_nx  = {r_quo[30:0], !w_rem_sub[32]};

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_prod <= 64'($signed({i_dec.sgn & i_dec.req.rs_value[31], i_dec.req.rs_value}) *
                          $signed({i_dec.sgn & i_dec.req.rt_value[31], i_dec.req.rt_value}));
            r_acc  <= i_dec.acc;
            r_dvs  <= w_bmag;
            r_qneg <= i_dec.sgn && (i_dec.req.rs_value[31] ^ i_dec.req.rt_value[31]);
            r_rneg <= i_dec.sgn && i_dec.req.rs_value[31];
        end
        if (o_take) begin
            r_rem <= '0;
            r_quo <= w_amag;
        end else if (r_state == ST_DIV) begin
            r_rem <= w_rem_nx;
            r_quo <= w_quo_nx;
        end
        if (w_load) begin
            r_out <= w_alu;
        end else if (r_state == ST_DONE && w_slot) begin
            r_out <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hi        <= '0;
            r_lo        <= '0;
            r_cnt       <= '0;
        end else begin
            if (w_load || (r_state == ST_DONE && w_slot)) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_load) begin
                        r_hi <= w_hi_alu;
                        r_lo <= w_lo_alu;
                    end else if (o_take && i_dec.cls == mieu_pkg::CLS_MUL) begin
                        r_state <= ST_MUL;
                    end else if (o_take && i_dec.cls == mieu_pkg::CLS_DIV) begin
                        if (i_dec.req.rt_value == '0) begin
                            r_hi    <= i_dec.req.rs_value;
                            r_lo    <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_MUL: begin
                    r_hi    <= w_mac[63:32];
                    r_lo    <= w_mac[31:0];
                    r_state <= ST_DONE;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_lo    <= r_qneg ? (32'd0 - w_quo_nx) : w_quo_nx;
                        r_hi    <= r_rneg ? (32'd0 - w_rem_nx) : w_rem_nx;
                        r_state <= ST_DONE;
                    end
                end
                default: begin
                    if (w_slot) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_state == ST_IDLE))
        else $error("request taken while busy");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result lost");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !w_slot) |=> (r_state == ST_DONE))
        else $error("result dropped");

endmodule

`default_nettype wire

/* design/mips_integer_execute_unit_core.sv */
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_core
// 32-bit MIPS integer execute unit with HI/LO pair, queue interfaces.
// ----------------------------------------------------------------------------
// Requests enter a decode front and wait in a queue of QueueDepth entries; the
// back end executes one request at a time. ALU, shift, bit-field and HI/LO
// move results are computed combinationally and registered; multiply and
// multiply-accumulate pass through the product register, HI/LO accumulate,
// then the result; divide runs the restoring divider, forming the 32 quotient
// bits one at a time, then the result, or goes straight to the result for a
// zero divisor. One result is returned per request, in order.
`default_nettype none

module mips_integer_execute_unit_core #(
    parameter int QueueDepth = mieu_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              push,
    output logic             full,
    input  mieu_pkg::t_req   i_req,
    output logic             empty,
    input  wire              pop,
    output mieu_pkg::t_rsp   o_rsp
);

    logic           w_valid;
    logic           w_take;
    mieu_pkg::t_dec w_dec;

    mieu_front #(
        .Depth (QueueDepth)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (i_req),
        .o_full  (full),
        .o_valid (w_valid),
        .o_dec   (w_dec),
        .i_take  (w_take)
    );

    mieu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_dec   (w_dec),
        .o_take  (w_take),
        .o_empty (empty),
        .o_rsp   (o_rsp),
        .i_pop   (pop)
    );

endmodule

`default_nettype wire
